// ===== design/vl2_pkg.sv =====
package vl2_pkg;

  localparam int ELEM_W      = 16;
  localparam int IO_LANES    = 4;
  localparam int LANES       = 4;
  localparam int CNT_W       = 3;
  localparam int FRAC_BITS   = 12;
  localparam int ACC_W       = 48;
  localparam int OPND_W      = ELEM_W + 1;
  localparam int PROD_W      = 2 * OPND_W;
  localparam int SUM_W       = PROD_W + 2;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [ACC_W-1:0] ONE_VAL = ACC_W'(1) << (2 * FRAC_BITS);

  typedef enum logic {
    MODE_SQDIFF = 1'b0,
    MODE_DOT    = 1'b1
  } metric_t;

  typedef logic signed [ELEM_W-1:0] elem_t;

  typedef struct packed {
    elem_t [IO_LANES-1:0] a;
    elem_t [IO_LANES-1:0] b;
    logic  [IO_LANES-1:0] lane_en;
    logic                 last;
    metric_t              mode;
  } item_t;

endpackage

// ===== design/vl2_front.sv =====
module vl2_front (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  vl2_pkg::elem_t [vl2_pkg::IO_LANES-1:0] a,
  input  vl2_pkg::elem_t [vl2_pkg::IO_LANES-1:0] b,
  input  logic [vl2_pkg::CNT_W-1:0]     lanes_valid,
  input  logic                          last_item,
  input  vl2_pkg::metric_t              mode,
  output logic                          push_valid,
  input  logic                          push_ready,
  output vl2_pkg::item_t                push_data
);

  logic [vl2_pkg::CNT_W-1:0] n_sat;

  always_comb begin
    if (lanes_valid > vl2_pkg::CNT_W'(vl2_pkg::LANES)) begin
      n_sat = vl2_pkg::CNT_W'(vl2_pkg::LANES);
    end else begin
      n_sat = lanes_valid;
    end
  end

  always_comb begin
    push_data.a    = a;
    push_data.b    = b;
    push_data.last = last_item;
    push_data.mode = mode;
    for (int i = 0; i < vl2_pkg::IO_LANES; i++) begin
      push_data.lane_en[i] = vl2_pkg::CNT_W'(i) < n_sat;
    end
  end

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule

// ===== design/vl2_queue.sv =====
module vl2_queue #(
  parameter int DEPTH = vl2_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  vl2_pkg::item_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output vl2_pkg::item_t pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  vl2_pkg::item_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign push_ready = count_r != CNT_W'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== design/vl2_back.sv =====
module vl2_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      pop_valid,
  output logic                      pop_ready,
  input  vl2_pkg::item_t            pop_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [vl2_pkg::ACC_W-1:0] out_distance
);

  localparam int AW = vl2_pkg::ACC_W;
  localparam int SW = vl2_pkg::SUM_W;
  localparam int PW = vl2_pkg::PROD_W;
  localparam int OW = vl2_pkg::OPND_W;

  logic                                adv;

  logic                                s1_valid_r;
  logic signed [PW-1:0]                s1_prod_r [vl2_pkg::IO_LANES];
  logic                                s1_last_r;
  vl2_pkg::metric_t                    s1_mode_r;

  logic                                s2_valid_r;
  logic signed [SW-1:0]                s2_sum_r;
  logic                                s2_last_r;
  vl2_pkg::metric_t                    s2_mode_r;

  logic [AW-1:0]                       acc_r, acc_nxt;
  logic [AW-1:0]                       acc_neg_r, acc_neg_nxt;
  logic [AW-1:0]                       sum_ext;
  logic                                out_valid_r;
  logic [AW-1:0]                       out_distance_r;

  logic signed [OW-1:0]                op_x [vl2_pkg::IO_LANES];
  logic signed [OW-1:0]                op_y [vl2_pkg::IO_LANES];
  logic signed [PW-1:0]                prod [vl2_pkg::IO_LANES];
  logic signed [SW-1:0]                sum_c;

  // the pipeline stalls only when a result must land on a full output register
  assign adv       = !(s2_valid_r && s2_last_r && out_valid_r && !out_ready);
  assign pop_ready = adv;

  always_comb begin
    for (int i = 0; i < vl2_pkg::IO_LANES; i++) begin
      if (pop_data.mode == vl2_pkg::MODE_DOT) begin
        op_x[i] = OW'($signed(pop_data.a[i]));
        op_y[i] = OW'($signed(pop_data.b[i]));
      end else begin
        op_x[i] = OW'($signed(pop_data.a[i])) - OW'($signed(pop_data.b[i]));
        op_y[i] = op_x[i];
      end
      prod[i] = pop_data.lane_en[i] ? PW'(op_x[i] * op_y[i]) : '0;
    end
  end

  always_comb begin
    sum_c = '0;
    for (int i = 0; i < vl2_pkg::IO_LANES; i++) begin
      sum_c = sum_c + SW'(s1_prod_r[i]);
    end
  end

  assign sum_ext = AW'(s2_sum_r);

  // acc_neg_r tracks ONE_VAL - acc_r so the inner-product result needs no extra add
  always_comb begin
    acc_nxt     = acc_r;
    acc_neg_nxt = acc_neg_r;
    if (adv && s2_valid_r) begin
      if (s2_last_r) begin
        acc_nxt     = '0;
        acc_neg_nxt = vl2_pkg::ONE_VAL;
      end else begin
        acc_nxt     = acc_r + sum_ext;
        acc_neg_nxt = acc_neg_r - sum_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      acc_r       <= '0;
      acc_neg_r   <= vl2_pkg::ONE_VAL;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        s1_valid_r <= pop_valid;
        s2_valid_r <= s1_valid_r;
      end
      acc_r     <= acc_nxt;
      acc_neg_r <= acc_neg_nxt;
      if (adv && s2_valid_r && s2_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_prod_r <= prod;
      s1_last_r <= pop_data.last;
      s1_mode_r <= pop_data.mode;
      s2_sum_r  <= sum_c;
      s2_last_r <= s1_last_r;
      s2_mode_r <= s1_mode_r;
    end
    if (adv && s2_valid_r && s2_last_r) begin
      if (s2_mode_r == vl2_pkg::MODE_DOT) begin
        out_distance_r <= acc_neg_r - sum_ext;
      end else begin
        out_distance_r <= acc_r + sum_ext;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;

endmodule

// ===== design/vector_l2_ip_distance.sv =====
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    a/b lanes 0..3, lanes_valid, last_item
// out_      output     out_valid / out_ready  distance (48-bit signed, Q24.24)
// cfg_      input      cfg_wr_en              metric_mode
//
// One transaction per cycle sustained while out_ready does not stall the output;
// a last transaction's result passes the queue, s1, s2 and output registers in turn.
// The 4-lane multiply stage, adder tree and accumulator are each one register stage.
// rst_n is synchronous: clears the queue, pipeline valids, accumulator and mode.
// The input side stalls only when the queue is full; the pipeline stalls only
// when a result meets an output register still waiting on out_ready.
module vector_l2_ip_distance #(
  parameter int QUEUE_DEPTH = vl2_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [vl2_pkg::ELEM_W-1:0] in_a_lane0,
  input  logic signed [vl2_pkg::ELEM_W-1:0] in_a_lane1,
  input  logic signed [vl2_pkg::ELEM_W-1:0] in_a_lane2,
  input  logic signed [vl2_pkg::ELEM_W-1:0] in_a_lane3,
  input  logic signed [vl2_pkg::ELEM_W-1:0] in_b_lane0,
  input  logic signed [vl2_pkg::ELEM_W-1:0] in_b_lane1,
  input  logic signed [vl2_pkg::ELEM_W-1:0] in_b_lane2,
  input  logic signed [vl2_pkg::ELEM_W-1:0] in_b_lane3,
  input  logic [vl2_pkg::CNT_W-1:0]        in_lanes_valid,
  input  logic                             in_last_item,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [vl2_pkg::ACC_W-1:0] out_distance,
  input  logic                             cfg_wr_en,
  input  logic                             cfg_wr_data
);

  vl2_pkg::metric_t metric_mode_r;
  vl2_pkg::elem_t [vl2_pkg::IO_LANES-1:0] a_vec, b_vec;
  vl2_pkg::item_t   push_data, pop_data;
  logic             push_valid, push_ready, pop_valid, pop_ready;
  logic [vl2_pkg::ACC_W-1:0] dist_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metric_mode_r <= vl2_pkg::MODE_SQDIFF;
    end else if (cfg_wr_en) begin
      metric_mode_r <= vl2_pkg::metric_t'(cfg_wr_data);
    end
  end

  assign a_vec = {in_a_lane3, in_a_lane2, in_a_lane1, in_a_lane0};
  assign b_vec = {in_b_lane3, in_b_lane2, in_b_lane1, in_b_lane0};

  vl2_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .a           (a_vec),
    .b           (b_vec),
    .lanes_valid (in_lanes_valid),
    .last_item   (in_last_item),
    .mode        (metric_mode_r),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  vl2_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  vl2_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_data     (pop_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_distance (dist_raw)
  );

  assign out_distance = $signed(dist_raw);

endmodule

// ===== design/vl2_checker.sv =====
module vl2_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      in_last_item,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [vl2_pkg::ACC_W-1:0] out_distance
);

  logic [7:0] pending_r;
  logic       in_last_acc, out_acc;

  assign in_last_acc = in_valid && in_ready && in_last_item;
  assign out_acc     = out_valid && out_ready;

  // last transactions accepted whose result has not yet been taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (in_last_acc && !out_acc) begin
      pending_r <= pending_r + 8'd1;
    end else if (out_acc && !in_last_acc) begin
      pending_r <= pending_r - 8'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distance))
    else $error("result changed or dropped while stalled");

  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("not idle after reset");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 8'd0)
    else $error("result without a pending last transaction");

  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && pending_r == 8'd1 && !in_last_acc |=> !out_valid)
    else $error("result repeated");

endmodule

bind vector_l2_ip_distance vl2_checker u_vl2_checker (.*);

// ===== verif/vector_l2_ip_distance_test.sv =====
module vector_l2_ip_distance_test;
  import vl2_pkg::*;

  typedef elem_t [IO_LANES-1:0] lanes_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  elem_t                   in_a_lane0 = '0;
  elem_t                   in_a_lane1 = '0;
  elem_t                   in_a_lane2 = '0;
  elem_t                   in_a_lane3 = '0;
  elem_t                   in_b_lane0 = '0;
  elem_t                   in_b_lane1 = '0;
  elem_t                   in_b_lane2 = '0;
  elem_t                   in_b_lane3 = '0;
  logic [CNT_W-1:0]        in_lanes_valid = '0;
  logic                    in_last_item = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [ACC_W-1:0] out_distance;
  logic                    cfg_wr_en = 1'b0;
  logic                    cfg_wr_data = 1'b0;

  // predictor state
  metric_t                 cur_metric = MODE_SQDIFF;
  logic [ACC_W-1:0]        acc_sum = '0;
  logic signed [ACC_W-1:0] dist_q[$];
  logic signed [ACC_W-1:0] dist_exp;

  int  err_cnt = 0;
  int  item_cnt = 0;
  int  rx_hold = 0;
  bit  tx_idle_en = 1'b1;
  bit  rx_idle_en = 1'b1;

  vector_l2_ip_distance u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_a_lane0     (in_a_lane0),
    .in_a_lane1     (in_a_lane1),
    .in_a_lane2     (in_a_lane2),
    .in_a_lane3     (in_a_lane3),
    .in_b_lane0     (in_b_lane0),
    .in_b_lane1     (in_b_lane1),
    .in_b_lane2     (in_b_lane2),
    .in_b_lane3     (in_b_lane3),
    .in_lanes_valid (in_lanes_valid),
    .in_last_item   (in_last_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_distance   (out_distance),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always #1 clk = ~clk;

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic elem_t rand_elem();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return elem_t'(16'sh7fff);
      1: return elem_t'(16'sh8000);
      2: return elem_t'($urandom_range(0, 31)) - elem_t'(16);
      default: return elem_t'($urandom);
    endcase
  endfunction

  function automatic lanes_t rand_lanes();
    lanes_t v;
    for (int i = 0; i < IO_LANES; i++) v[i] = rand_elem();
    return v;
  endfunction

  function automatic lanes_t all_lanes(elem_t v);
    return {IO_LANES{v}};
  endfunction

  // accumulate one accepted transaction, queue the distance on a last one
  function automatic void predict_distance(lanes_t a, lanes_t b, logic [CNT_W-1:0] cnt,
                                           logic last);
    int                      n;
    logic signed [OPND_W-1:0] diff;
    logic signed [ACC_W-1:0] term;
    n = (cnt > LANES) ? LANES : int'(cnt);
    for (int i = 0; i < n; i++) begin
      if (cur_metric == MODE_DOT) begin
        term = a[i] * b[i];
      end else begin
        diff = a[i] - b[i];
        term = diff * diff;
      end
      acc_sum = acc_sum + term;
    end
    if (last) begin
      dist_q.push_back((cur_metric == MODE_DOT) ? ONE_VAL - acc_sum : acc_sum);
      acc_sum = '0;
    end
  endfunction

  task automatic send_item(lanes_t a, lanes_t b, logic [CNT_W-1:0] cnt, logic last);
    int gap;
    in_valid       <= 1'b1;
    in_a_lane0     <= a[0];
    in_a_lane1     <= a[1];
    in_a_lane2     <= a[2];
    in_a_lane3     <= a[3];
    in_b_lane0     <= b[0];
    in_b_lane1     <= b[1];
    in_b_lane2     <= b[2];
    in_b_lane3     <= b[3];
    in_lanes_valid <= cnt;
    in_last_item   <= last;
    do @(posedge clk); while (!(in_valid && in_ready));
    predict_distance(a, b, cnt, last);
    item_cnt++;
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender holds off until every queued distance is back and the pipe has settled
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (dist_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_metric(metric_t m);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cur_metric = m;
  endtask

  task automatic send_vector(int len);
    logic [CNT_W-1:0] cnt;
    for (int k = 0; k < len; k++) begin
      if (k == len - 1) cnt = CNT_W'($urandom_range(0, 7));
      else cnt = ($urandom_range(0, 9) < 7) ? CNT_W'(LANES) : CNT_W'($urandom_range(0, 7));
      send_item(rand_lanes(), rand_lanes(), cnt, k == len - 1);
    end
  endtask

  task automatic test_extremes();
    set_metric(MODE_SQDIFF);
    send_item(all_lanes(16'sh7fff), all_lanes(16'sh8000), 3'd4, 1'b1);
    send_item(all_lanes(16'sh8000), all_lanes(16'sh7fff), 3'd4, 1'b1);
    set_metric(MODE_DOT);
    send_item(all_lanes(16'sh8000), all_lanes(16'sh8000), 3'd4, 1'b1);
    send_item(all_lanes(16'sh7fff), all_lanes(16'sh8000), 3'd4, 1'b1);
    send_item(all_lanes(16'sh0000), all_lanes(16'sh0000), 3'd4, 1'b1);
  endtask

  task automatic test_lane_counts();
    set_metric(MODE_SQDIFF);
    for (int c = 0; c < 8; c++) begin
      send_item(all_lanes(16'sh1234), all_lanes(16'shedcb), CNT_W'(c), 1'b1);
    end
    send_item(rand_lanes(), rand_lanes(), 3'd0, 1'b0);
    send_item(rand_lanes(), rand_lanes(), 3'd4, 1'b1);
  endtask

  task automatic test_mode_mid_vector();
    set_metric(MODE_SQDIFF);
    send_item(rand_lanes(), rand_lanes(), 3'd4, 1'b0);
    send_item(rand_lanes(), rand_lanes(), 3'd3, 1'b0);
    set_metric(MODE_DOT);
    send_item(rand_lanes(), rand_lanes(), 3'd4, 1'b1);
    send_item(rand_lanes(), rand_lanes(), 3'd4, 1'b0);
    set_metric(MODE_SQDIFF);
    send_item(rand_lanes(), rand_lanes(), 3'd2, 1'b0);
    send_item(rand_lanes(), rand_lanes(), 3'd4, 1'b1);
  endtask

  task automatic test_hold_until_drained();
    send_vector(2);
    send_vector(1);
    wait_idle();
    send_vector(1);
  endtask

  // long vector of extreme values: L2 sum climbs to about 2^42
  task automatic test_long_vector();
    set_metric(MODE_SQDIFF);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    for (int k = 0; k < 256; k++) begin
      send_item(all_lanes(16'sh7fff), all_lanes(16'sh8000), 3'd4, k == 255);
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic test_random_vectors();
    int r;
    int base;
    int phase_end;
    base = item_cnt;
    while (item_cnt - base < 1550) begin
      set_metric(metric_t'($urandom_range(0, 1)));
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      phase_end = item_cnt + $urandom_range(100, 250);
      while (item_cnt < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 70) send_vector($urandom_range(1, 4));
        else if (r < 95) send_vector($urandom_range(5, 16));
        else send_vector($urandom_range(17, 128));
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rx_hold   <= rx_hold - 1;
      out_ready <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
      rx_hold   <= pick_gap();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (dist_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected distance transaction: %0d", out_distance);
      end else begin
        dist_exp = dist_q.pop_front();
        if (out_distance !== dist_exp) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("distance mismatch: expected %0d actual %0d", dist_exp, out_distance);
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_lane_counts();
    test_mode_mid_vector();
    test_hold_until_drained();
    test_long_vector();
    test_random_vectors();
    wait_idle();
    repeat (20) @(posedge clk);
    if (err_cnt == 0 && dist_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/vl2_pkg.sv
design/vl2_front.sv
design/vl2_queue.sv
design/vl2_back.sv
design/vector_l2_ip_distance.sv
design/vl2_checker.sv
verif/vector_l2_ip_distance_test.sv
